// ===== design/rpg_pkg.sv =====
// Shared types, constants and helper functions for the rainbow pixel generator.
// No dependencies; imported by every other design file.

package rpg_pkg;

    localparam int COLUMN_W = 4;
    localparam int ROW_W    = 5;
    localparam int INDEX_W  = 9;
    localparam int HUE_W    = 16;
    localparam int CHAN_W   = 8;
    localparam int CFG_W    = 16;

    typedef enum logic [2:0] {
        CFG_HUE_STEP    = 3'd0,
        CFG_COLUMN_GAIN = 3'd1,
        CFG_ROW_GAIN    = 3'd2,
        CFG_SATURATION  = 3'd3,
        CFG_VALUE       = 3'd4,
        CFG_SERPENTINE  = 3'd5,
        CFG_MIRROR_X    = 3'd6,
        CFG_MIRROR_Y    = 3'd7
    } t_cfg_reg;

    localparam logic [HUE_W-1:0]  RST_HUE_STEP    = 16'd12;
    localparam logic [HUE_W-1:0]  RST_COLUMN_GAIN = 16'd40;
    localparam logic [HUE_W-1:0]  RST_ROW_GAIN    = 16'd10;
    localparam logic [CHAN_W-1:0] RST_SATURATION  = 8'd255;
    localparam logic [CHAN_W-1:0] RST_VALUE       = 8'd120;
    localparam logic              RST_SERPENTINE  = 1'b1;
    localparam logic              RST_MIRROR_X    = 1'b0;
    localparam logic              RST_MIRROR_Y    = 1'b0;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_step;
        logic [HUE_W-1:0]  column_gain;
        logic [HUE_W-1:0]  row_gain;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] value;
        logic              serpentine;
        logic              mirror_x;
        logic              mirror_y;
    } t_cfg;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [INDEX_W-1:0] led_index;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        B_IDLE,
        B_STAGE2,
        B_STAGE3,
        B_HOLD
    } t_back_state;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // floor(x / 255) for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // (h / 256) mod 6 of a hue, via reciprocal multiply of the high byte
    function automatic t_sector sector_of(input logic [HUE_W-1:0] hue);
        logic [17:0] prod;
        logic [5:0]  quot;
        logic [8:0]  rem;
        prod = 18'(hue[15:8]) * 18'd171;
        quot = prod[15:10];
        rem  = 9'(hue[15:8]) - 9'(quot) * 9'd6;
        return t_sector'(rem[2:0]);
    endfunction

endpackage

// ===== design/rpg_if.sv =====
// Handshake channels of the rainbow pixel generator: pixel words in, colour words out.
// Depends on rpg_pkg for field widths.

interface rpg_pixel_if;
    import rpg_pkg::*;
    logic                valid;
    logic                ready;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                frame_end;

    modport source (output valid, output column, output row, output frame_end, input ready);
    modport sink   (input valid, input column, input row, input frame_end, output ready);
endinterface

interface rpg_result_if;
    import rpg_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] led_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;

    modport source (output valid, output led_index, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input led_index, input red, input green, input blue,
                    output ready);
endinterface

// ===== design/rpg_front.sv =====
// Front end: accepts pixel words, forms the hue and the LED chain index, keeps the hue offset.
// Depends on rpg_pkg and rpg_pixel_if.

module rpg_front
    import rpg_pkg::*;
#(
    parameter int PANEL_WIDTH  = 16,
    parameter int PANEL_HEIGHT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    rpg_pixel_if.sink      i_pixel,
    input  logic           i_full,
    output logic           o_push,
    output t_entry         o_entry
);

    localparam logic [8:0] W   = 9'(PANEL_WIDTH);
    localparam logic [8:0] H   = 9'(PANEL_HEIGHT);
    localparam logic [8:0] WM1 = 9'(PANEL_WIDTH - 1);
    localparam logic [8:0] HM1 = 9'(PANEL_HEIGHT - 1);

    logic [HUE_W-1:0] r_offset;
    logic [HUE_W-1:0] n_offset;
    logic [19:0]      col_term;
    logic [20:0]      row_term;
    logic [8:0]       x;
    logic [8:0]       y;
    logic             outside;
    logic [17:0]      flat;

    assign i_pixel.ready = !i_full;
    assign o_push        = i_pixel.valid && !i_full;

    assign col_term = 20'(i_pixel.column) * 20'(i_cfg.column_gain);
    assign row_term = 21'(i_pixel.row) * 21'(i_cfg.row_gain);

    always_comb begin
        x       = 9'(i_pixel.column);
        y       = 9'(i_pixel.row);
        outside = 1'b0;
        if (i_cfg.mirror_x) begin
            if (x > WM1) outside = 1'b1;
            x = WM1 - x;
        end
        if (i_cfg.mirror_y) begin
            if (y > HM1) outside = 1'b1;
            y = HM1 - y;
        end
        if (x >= W || y >= H) outside = 1'b1;
        if (i_cfg.serpentine && y[0]) x = WM1 - x;
        flat = 18'(y) * 18'(W) + 18'(x);
        o_entry.hue       = 16'(r_offset + col_term[15:0] + row_term[15:0]);
        o_entry.led_index = outside ? '0 : flat[INDEX_W-1:0];
    end

    always_comb begin
        n_offset = r_offset;
        if (o_push && i_pixel.frame_end) n_offset = 16'(r_offset + i_cfg.hue_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

// ===== design/rpg_queue.sv =====
// Two-word queue between the front and back ends.
// Depends on rpg_pkg for the entry and status types.

module rpg_queue
    import rpg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_entry        i_entry,
    input  logic          i_pop,
    output t_entry        o_head,
    output t_queue_status o_status
);

    localparam int DEPTH = 2;

    t_entry     r_mem [DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_head          = r_mem[r_rd];
    assign o_status.full   = (r_count == 2'(DEPTH));
    assign o_status.empty  = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/rpg_back.sv =====
// Back end: six-sector HSV to RGB conversion over three register stages, then the result word.
// Depends on rpg_pkg and rpg_result_if.

module rpg_back
    import rpg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_entry        i_head,
    input  t_queue_status i_status,
    output logic          o_pop,
    rpg_result_if.source  o_result
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic               ld_stage2;
    logic               ld_stage3;

    t_sector            r_sector;
    logic [INDEX_W-1:0] r_idx;
    logic [15:0]        r_sf;
    logic [15:0]        r_sfc;
    logic [15:0]        r_vs;
    logic [15:0]        r_vq;
    logic [15:0]        r_vt;
    logic [CHAN_W-1:0]  r_p;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;

    logic [CHAN_W-1:0]  f;
    logic [CHAN_W-1:0]  qs;
    logic [CHAN_W-1:0]  ts;
    logic [CHAN_W-1:0]  q;
    logic [CHAN_W-1:0]  t;
    logic [CHAN_W-1:0]  v;
    logic [CHAN_W-1:0]  n_red;
    logic [CHAN_W-1:0]  n_green;
    logic [CHAN_W-1:0]  n_blue;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (!i_status.empty) n_state = B_STAGE2;
            B_STAGE2: n_state = B_STAGE3;
            B_STAGE3: n_state = B_HOLD;
            B_HOLD:   if (o_result.ready) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = (r_state == B_IDLE) && !i_status.empty;
        ld_stage2      = (r_state == B_STAGE2);
        ld_stage3      = (r_state == B_STAGE3);
        o_result.valid = (r_state == B_HOLD);
    end

    assign f  = i_head.hue[7:0];
    assign qs = CHAN_MAX - div255(r_sf);
    assign ts = CHAN_MAX - div255(r_sfc);
    assign q  = div255(r_vq);
    assign t  = div255(r_vt);
    assign v  = i_cfg.value;

    always_comb begin
        case (r_sector)
            SEC_0: begin n_red = v;   n_green = t;   n_blue = r_p; end
            SEC_1: begin n_red = q;   n_green = v;   n_blue = r_p; end
            SEC_2: begin n_red = r_p; n_green = v;   n_blue = t;   end
            SEC_3: begin n_red = r_p; n_green = q;   n_blue = v;   end
            SEC_4: begin n_red = t;   n_green = r_p; n_blue = v;   end
            default: begin n_red = v; n_green = r_p; n_blue = q;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sector <= sector_of(i_head.hue);
            r_idx    <= i_head.led_index;
            r_sf     <= 16'(i_cfg.saturation) * 16'(f);
            r_sfc    <= 16'(i_cfg.saturation) * 16'(CHAN_MAX - f);
            r_vs     <= 16'(v) * 16'(CHAN_MAX - i_cfg.saturation);
        end
        if (ld_stage2) begin
            r_vq <= 16'(v) * 16'(qs);
            r_vt <= 16'(v) * 16'(ts);
            r_p  <= div255(r_vs);
        end
        if (ld_stage3) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_result.led_index = r_idx;
    assign o_result.red       = r_red;
    assign o_result.green     = r_green;
    assign o_result.blue      = r_blue;

endmodule

// ===== design/rainbow_pixel_generator_core.sv =====
// Top level of the rainbow pixel generator: configuration registers, front, queue, back.
// Depends on rpg_pkg, rpg_if, rpg_front, rpg_queue and rpg_back.

// Each pixel word gives one colour word. The front end takes a pixel word in any cycle in
// which the two-entry queue has room; the back end takes each word through two multiply
// stages, the output register and a hold state that lasts until the result is taken, and
// pops no new word from the queue before then. A frame-end mark advances the hue offset
// for the words that follow it. Write configuration only while no word is in flight.

module rainbow_pixel_generator_core
    import rpg_pkg::*;
#(
    parameter int PANEL_WIDTH  = 16,
    parameter int PANEL_HEIGHT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    rpg_pixel_if.sink        i_pixel,
    rpg_result_if.source     o_result
);

    t_cfg          r_cfg;
    t_cfg          n_cfg;
    logic          push;
    logic          pop;
    t_entry        entry;
    t_entry        head;
    t_queue_status q_status;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_HUE_STEP:    n_cfg.hue_step    = i_cfg_data;
                CFG_COLUMN_GAIN: n_cfg.column_gain = i_cfg_data;
                CFG_ROW_GAIN:    n_cfg.row_gain    = i_cfg_data;
                CFG_SATURATION:  n_cfg.saturation  = i_cfg_data[CHAN_W-1:0];
                CFG_VALUE:       n_cfg.value       = i_cfg_data[CHAN_W-1:0];
                CFG_SERPENTINE:  n_cfg.serpentine  = i_cfg_data[0];
                CFG_MIRROR_X:    n_cfg.mirror_x    = i_cfg_data[0];
                CFG_MIRROR_Y:    n_cfg.mirror_y    = i_cfg_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_step    <= RST_HUE_STEP;
            r_cfg.column_gain <= RST_COLUMN_GAIN;
            r_cfg.row_gain    <= RST_ROW_GAIN;
            r_cfg.saturation  <= RST_SATURATION;
            r_cfg.value       <= RST_VALUE;
            r_cfg.serpentine  <= RST_SERPENTINE;
            r_cfg.mirror_x    <= RST_MIRROR_X;
            r_cfg.mirror_y    <= RST_MIRROR_Y;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rpg_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pixel (i_pixel),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_entry (entry)
    );

    rpg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    rpg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_result (o_result)
    );

    a_queue_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("back end pops an empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("front end pushes into a full queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result.valid)
        else $error("result word valid straight after reset");

endmodule
